// ===== hdl/assert_macros.svh =====
// Shared assertion macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dto_pkg.sv =====
`default_nettype none

package dto_pkg;

  // Count limits applied to the configuration registers
  localparam int MAX_FIXED_VARS = 32;
  localparam int MAX_KEPT_VARS  = 255;

  // Configuration register map (index = paddr[3:2])
  localparam int CFG_ADDR_W = 4;
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FIXED_VAR_COUNT = 2'd0;
  localparam reg_idx_t REG_KEPT_VAR_COUNT  = 2'd1;
  localparam reg_idx_t REG_SYSTEM_DEGREE   = 2'd2;

  // Degree and derivative order codes
  localparam logic [2:0] DEGREE_PARTIAL = 3'd3;
  localparam logic [2:0] DEGREE_FULL    = 3'd4;
  localparam logic [2:0] ORD_FUNC   = 3'd0;
  localparam logic [2:0] ORD_FIRST  = 3'd1;
  localparam logic [2:0] ORD_SECOND = 3'd2;
  localparam logic [2:0] ORD_THIRD  = 3'd3;
  localparam logic [2:0] ORD_FOURTH = 3'd4;

  // Binomial coefficient tables, C(n,k) for n = 0..63
  typedef logic [19:0] choose_tab_t [0:63];

  function automatic choose_tab_t build_choose(input int k);
    choose_tab_t tab;
    int c [0:4];
    int n;
    int j;
    for (j = 0; j <= 4; j++) begin
      c[j] = (j == 0) ? 1 : 0;
    end
    for (n = 0; n < 64; n++) begin
      tab[n] = 20'(c[k]);
      // Pascal step: row n -> row n+1
      for (j = 4; j >= 1; j--) begin
        c[j] = c[j] + c[j-1];
      end
    end
    return tab;
  endfunction

  localparam choose_tab_t C2_TAB = build_choose(2);
  localparam choose_tab_t C3_TAB = build_choose(3);
  localparam choose_tab_t C4_TAB = build_choose(4);

endpackage

`default_nettype wire

// ===== hdl/derivative_table_offset.sv =====
// An accepted request passes the register stages table, multiply, scale and sum to out_tvalid.
// Throughput: one request per cycle; the four register stages each hold one item,
// and a stalled output holds only the stages that are full behind it.
// Reset (rst_n low, synchronous): all stage valid bits clear, fixed_var_count and
// kept_var_count go to 0 and system_degree to 3.
`default_nettype none

module derivative_table_offset (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] order, [7:3] first_index, [12:8] second_index,
  // [17:13] third_index, [22:18] fourth_index, [23] zero
  input  wire logic [23:0]                      in_tdata,
  // Result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [20:0] word_offset, [41:21] store_words, [42] status, [47:43] zero
  output logic [47:0]                           out_tdata,
  // Configuration port
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [dto_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [31:0]                      cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [5:0] cfg_fixed_r;
  logic [7:0] cfg_kept_r;
  logic [2:0] cfg_degree_r;
  dto_pkg::reg_idx_t cfg_idx;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fixed_r  <= 6'd0;
      cfg_kept_r   <= 8'd0;
      cfg_degree_r <= dto_pkg::DEGREE_PARTIAL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dto_pkg::REG_FIXED_VAR_COUNT: cfg_fixed_r  <= cfg_pwdata[5:0];
        dto_pkg::REG_KEPT_VAR_COUNT:  cfg_kept_r   <= cfg_pwdata[7:0];
        dto_pkg::REG_SYSTEM_DEGREE:   cfg_degree_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      dto_pkg::REG_FIXED_VAR_COUNT: cfg_prdata = {26'd0, cfg_fixed_r};
      dto_pkg::REG_KEPT_VAR_COUNT:  cfg_prdata = {24'd0, cfg_kept_r};
      dto_pkg::REG_SYSTEM_DEGREE:   cfg_prdata = {29'd0, cfg_degree_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage takes new data when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !s4_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_tvalid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp counts, binomial table lookups
  // ---------------------------------------------------------------------------
  logic [2:0] in_ord;
  logic [4:0] in_i1, in_i2, in_i3, in_i4;
  logic [5:0] fix_clamp;
  logic [7:0] kept_clamp;
  logic       deg4_nxt;

  assign in_ord = in_tdata[2:0];
  assign in_i1  = in_tdata[7:3];
  assign in_i2  = in_tdata[12:8];
  assign in_i3  = in_tdata[17:13];
  assign in_i4  = in_tdata[22:18];

  assign fix_clamp  = (32'(cfg_fixed_r) > dto_pkg::MAX_FIXED_VARS)
                      ? 6'(dto_pkg::MAX_FIXED_VARS) : cfg_fixed_r;
  assign kept_clamp = (32'(cfg_kept_r) > dto_pkg::MAX_KEPT_VARS)
                      ? 8'(dto_pkg::MAX_KEPT_VARS) : cfg_kept_r;
  assign deg4_nxt   = (cfg_degree_r >= dto_pkg::DEGREE_FULL);

  logic [2:0]  s1_ord_r;
  logic        s1_err_r;
  logic        s1_deg4_r;
  logic [8:0]  s1_w_r;
  logic [5:0]  s1_f1_r;
  logic [8:0]  s1_c2f_r;
  logic [12:0] s1_c3f_r;
  logic [15:0] s1_c4f_r;
  logic [4:0]  s1_i1_r;
  logic [8:0]  s1_c2i_r;
  logic [12:0] s1_c3i_r;
  logic [14:0] s1_c4i_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_ord_r  <= in_ord;
      s1_err_r  <= in_ord > (deg4_nxt ? dto_pkg::DEGREE_FULL : dto_pkg::DEGREE_PARTIAL);
      s1_deg4_r <= deg4_nxt;
      s1_w_r    <= 9'(kept_clamp) + 9'd1;
      s1_f1_r   <= fix_clamp + 6'd1;
      s1_c2f_r  <= dto_pkg::C2_TAB[fix_clamp][8:0];
      s1_c3f_r  <= dto_pkg::C3_TAB[fix_clamp][12:0];
      s1_c4f_r  <= dto_pkg::C4_TAB[fix_clamp][15:0];
      s1_i1_r   <= in_i1;
      s1_c2i_r  <= dto_pkg::C2_TAB[{1'b0, in_i2}][8:0];
      s1_c3i_r  <= dto_pkg::C3_TAB[{1'b0, in_i3}][12:0];
      s1_c4i_r  <= dto_pkg::C4_TAB[{1'b0, in_i4}][14:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: region size products, rank sum, scale select
  // ---------------------------------------------------------------------------
  logic [8:0]  w3;
  logic [15:0] rank_nxt;
  logic [8:0]  wsel_nxt;

  assign w3 = s1_deg4_r ? s1_w_r : 9'd1;

  always_comb begin
    case (s1_ord_r)
      dto_pkg::ORD_FIRST: begin
        rank_nxt = 16'(s1_i1_r) + 16'd1;
        wsel_nxt = s1_w_r;
      end
      dto_pkg::ORD_SECOND: begin
        rank_nxt = 16'(s1_c2i_r) + 16'(s1_i1_r);
        wsel_nxt = s1_w_r;
      end
      dto_pkg::ORD_THIRD: begin
        rank_nxt = 16'(s1_c3i_r) + 16'(s1_c2i_r) + 16'(s1_i1_r);
        wsel_nxt = w3;
      end
      dto_pkg::ORD_FOURTH: begin
        rank_nxt = 16'(s1_c4i_r) + 16'(s1_c3i_r) + 16'(s1_c2i_r) + 16'(s1_i1_r);
        wsel_nxt = 9'd1;
      end
      default: begin
        rank_nxt = 16'd0;
        wsel_nxt = 9'd1;
      end
    endcase
  end

  logic [2:0]  s2_ord_r;
  logic        s2_err_r;
  logic [13:0] s2_p1_r;
  logic [16:0] s2_p2_r;
  logic [20:0] s2_p3_r;
  logic [15:0] s2_c4x_r;
  logic [15:0] s2_rank_r;
  logic [8:0]  s2_wsel_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_ord_r  <= s1_ord_r;
      s2_err_r  <= s1_err_r;
      s2_p1_r   <= 14'(s1_f1_r) * 14'(s1_w_r);
      s2_p2_r   <= 17'(s1_c2f_r) * 17'(s1_w_r);
      s2_p3_r   <= 21'(s1_c3f_r) * 21'(w3);
      s2_c4x_r  <= s1_deg4_r ? s1_c4f_r : 16'd0;
      s2_rank_r <= rank_nxt;
      s2_wsel_r <= wsel_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: third-order base, scaled rank
  // ---------------------------------------------------------------------------
  logic [2:0]  s3_ord_r;
  logic        s3_err_r;
  logic [13:0] s3_base2_r;
  logic [17:0] s3_base3_r;
  logic [20:0] s3_p3_r;
  logic [15:0] s3_c4x_r;
  logic [20:0] s3_q_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_ord_r   <= s2_ord_r;
      s3_err_r   <= s2_err_r;
      s3_base2_r <= s2_p1_r;
      s3_base3_r <= 18'(s2_p1_r) + 18'(s2_p2_r);
      s3_p3_r    <= s2_p3_r;
      s3_c4x_r   <= s2_c4x_r;
      s3_q_r     <= 21'(s2_rank_r) * 21'(s2_wsel_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: fourth-order base, total size, final offset (output register)
  // ---------------------------------------------------------------------------
  logic [20:0] base4;
  logic [20:0] total_nxt;
  logic [20:0] off_nxt;

  assign base4     = 21'(s3_base3_r) + s3_p3_r;
  assign total_nxt = base4 + 21'(s3_c4x_r);

  always_comb begin
    if (s3_err_r) begin
      off_nxt = 21'd0;
    end else begin
      case (s3_ord_r)
        dto_pkg::ORD_FIRST:  off_nxt = s3_q_r;
        dto_pkg::ORD_SECOND: off_nxt = 21'(s3_base2_r) + s3_q_r;
        dto_pkg::ORD_THIRD:  off_nxt = 21'(s3_base3_r) + s3_q_r;
        dto_pkg::ORD_FOURTH: off_nxt = base4 + s3_q_r;
        default:             off_nxt = 21'd0;
      endcase
    end
  end

  logic [20:0] s4_off_r;
  logic [20:0] s4_total_r;
  logic        s4_status_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_off_r    <= off_nxt;
      s4_total_r  <= total_nxt;
      s4_status_r <= s3_err_r;
    end
  end

  assign out_tvalid = s4_v_r;
  assign out_tdata  = {5'd0, s4_status_r, s4_total_r, s4_off_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready, s1_v_r, "accepted request not in stage 1")
  `ASSERT_NEXT(a_s2_holds_on_stall, clk, rst_n, s2_v_r && !rdy3, s2_v_r, "stage 2 item dropped while stalled")
  `ASSERT_IMPL(a_ok_order_in_range, clk, rst_n, s3_v_r && !s3_err_r, s3_ord_r <= dto_pkg::ORD_FOURTH, "order above four passed as ok")
  `ASSERT_IMPL(a_store_nonzero, clk, rst_n, out_tvalid, out_tdata[41:21] != 21'd0, "store size is zero")

endmodule

`default_nettype wire
